/* rtl/core/frp_pkg.sv */
// ----------------------------------------------------------------------------
// Framed packet receiver package
// Shared types, codes, reset values and the CRC-16/CCITT-FALSE byte update.
// ----------------------------------------------------------------------------
package frp_pkg;

  // Payload capacity default and fixed field widths.
  localparam int MAX_PAYLOAD_DEF = 64;
  localparam int LEN_W           = 7;
  localparam int POS_W           = 6;

  // Operation codes of an input word.
  localparam logic [1:0] OP_BYTE  = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_ABORT = 2'd2;

  // Event codes of a result word.
  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_PKT     = 2'd1;
  localparam logic [1:0] EV_CRC_ERR = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_SOF_FIRST  = 3'd0;
  localparam logic [2:0] REG_SOF_SECOND = 3'd1;
  localparam logic [2:0] REG_VERSION    = 3'd2;
  localparam logic [2:0] REG_TIMEOUT    = 3'd3;

  // Configuration reset values.
  localparam logic [7:0]  SOF_FIRST_RST  = 8'hAA;
  localparam logic [7:0]  SOF_SECOND_RST = 8'h55;
  localparam logic [7:0]  VERSION_RST    = 8'h01;
  localparam logic [15:0] TIMEOUT_RST    = 16'd100;

  // CRC constants.
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Parser phases, one-hot.
  typedef enum logic [8:0] {
    PH_SOF1 = 9'b000000001,
    PH_SOF2 = 9'b000000010,
    PH_VER  = 9'b000000100,
    PH_TYPE = 9'b000001000,
    PH_SEQ  = 9'b000010000,
    PH_LEN  = 9'b000100000,
    PH_PAY  = 9'b001000000,
    PH_CRCL = 9'b010000000,
    PH_CRCH = 9'b100000000
  } phase_t;

  // Per-frame parser context.
  typedef struct packed {
    phase_t           phase;
    logic [LEN_W-1:0] count;
    logic [LEN_W-1:0] len;
    logic [7:0]       typ;
    logic [7:0]       seq;
    logic [7:0]       crc_lo;
    logic [15:0]      crc;
    logic [31:0]      last_time;
  } frame_t;

  localparam frame_t FRAME_IDLE = '{
    phase:     PH_SOF1,
    count:     '0,
    len:       '0,
    typ:       '0,
    seq:       '0,
    crc_lo:    '0,
    crc:       CRC_INIT,
    last_time: '0
  };

  // Job handed from the parser to the result side.
  typedef struct packed {
    logic             acc;
    logic             tout;
    logic [1:0]       ev;
    logic [7:0]       typ;
    logic [7:0]       seq;
    logic [LEN_W-1:0] len;
    logic [31:0]      crc_errors;
    logic [31:0]      timeouts;
    logic             active;
  } job_t;

  // One result word.
  typedef struct packed {
    logic             acc;
    logic             tout;
    logic [1:0]       ev;
    logic [7:0]       typ;
    logic [7:0]       seq;
    logic [LEN_W-1:0] len;
    logic [7:0]       val;
    logic [POS_W-1:0] pos;
    logic             last;
    logic [31:0]      crc_errors;
    logic [31:0]      timeouts;
    logic             active;
  } res_t;

  // CRC-16/CCITT-FALSE update by one byte, MSB first.
  function automatic logic [15:0] crc_feed(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* rtl/core/frp_front.sv */
// ----------------------------------------------------------------------------
// Framed packet receiver front end
// Takes input words, runs the frame parser, timeout and CRC, writes payload
// bytes to the payload memory and pushes one job per word to the queue.
// ----------------------------------------------------------------------------
module frp_front
  import frp_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
  parameter int AW          = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [1:0]    in_op,
  input  logic [7:0]    in_data_byte,
  input  logic [31:0]   in_time_ms,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [15:0]   cfg_data,
  input  logic          q_full,
  output logic          q_push,
  output job_t          q_job,
  input  logic          deliver_done,
  output logic          mem_we,
  output logic [AW-1:0] mem_addr,
  output logic [7:0]    mem_data
);

  localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

  logic [7:0]  sof_first_r, sof_second_r, version_r;
  logic [15:0] timeout_r;
  frame_t      fr_r, fr_nxt;
  logic [31:0] crc_err_r, crc_err_nxt;
  logic [31:0] tout_cnt_r, tout_cnt_nxt;
  logic        pend_r, pend_nxt;

  logic             fire;
  logic             expire;
  logic [31:0]      elapsed;
  phase_t           ph;
  logic [LEN_W-1:0] count_inc;
  logic             acc, tout, deliver;
  logic [1:0]       ev;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sof_first_r  <= SOF_FIRST_RST;
      sof_second_r <= SOF_SECOND_RST;
      version_r    <= VERSION_RST;
      timeout_r    <= TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SOF_FIRST:  sof_first_r  <= cfg_data[7:0];
        REG_SOF_SECOND: sof_second_r <= cfg_data[7:0];
        REG_VERSION:    version_r    <= cfg_data[7:0];
        REG_TIMEOUT:    timeout_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Hold input while the queue is full or a delivered frame still drains.
  assign in_stall = q_full || pend_r;
  assign fire     = in_valid && !in_stall;

  // Wrap-safe inactivity check.
  assign elapsed = in_time_ms - fr_r.last_time;
  assign expire  = (fr_r.phase != PH_SOF1) && (elapsed >= {16'h0000, timeout_r});

  assign count_inc = fr_r.count + LEN_W'(1);

  // Parser next state.
  always_comb begin
    fr_nxt       = fr_r;
    crc_err_nxt  = crc_err_r;
    tout_cnt_nxt = tout_cnt_r;
    acc          = 1'b0;
    tout         = 1'b0;
    ev           = EV_NONE;
    deliver      = 1'b0;
    ph           = fr_r.phase;
    mem_we       = 1'b0;

    if (fire && (in_op == OP_BYTE || in_op == OP_TICK) && expire) begin
      tout         = 1'b1;
      tout_cnt_nxt = tout_cnt_r + 32'd1;
      fr_nxt       = FRAME_IDLE;
      ph           = PH_SOF1;
    end

    if (fire && in_op == OP_ABORT) begin
      fr_nxt = FRAME_IDLE;
    end

    if (fire && in_op == OP_BYTE) begin
      if (ph != PH_SOF1 || in_data_byte == sof_first_r) begin
        fr_nxt.last_time = in_time_ms;
      end
      case (ph)
        PH_SOF1: begin
          if (in_data_byte == sof_first_r) begin
            fr_nxt.phase = PH_SOF2;
            acc          = 1'b1;
          end
        end
        PH_SOF2: begin
          if (in_data_byte == sof_second_r) begin
            fr_nxt.phase = PH_VER;
            acc          = 1'b1;
          end else if (in_data_byte == sof_first_r) begin
            acc = 1'b1;
          end else begin
            fr_nxt = FRAME_IDLE;
          end
        end
        PH_VER: begin
          acc = 1'b1;
          if (in_data_byte != version_r) begin
            fr_nxt = FRAME_IDLE;
          end else begin
            fr_nxt.crc   = crc_feed(CRC_INIT, in_data_byte);
            fr_nxt.phase = PH_TYPE;
          end
        end
        PH_TYPE: begin
          acc          = 1'b1;
          fr_nxt.typ   = in_data_byte;
          fr_nxt.crc   = crc_feed(fr_r.crc, in_data_byte);
          fr_nxt.phase = PH_SEQ;
        end
        PH_SEQ: begin
          acc          = 1'b1;
          fr_nxt.seq   = in_data_byte;
          fr_nxt.crc   = crc_feed(fr_r.crc, in_data_byte);
          fr_nxt.phase = PH_LEN;
        end
        PH_LEN: begin
          acc = 1'b1;
          if (in_data_byte > MAX_LEN) begin
            fr_nxt = FRAME_IDLE;
          end else begin
            fr_nxt.len   = in_data_byte[LEN_W-1:0];
            fr_nxt.count = '0;
            fr_nxt.crc   = crc_feed(fr_r.crc, in_data_byte);
            fr_nxt.phase = (in_data_byte == 8'h00) ? PH_CRCL : PH_PAY;
          end
        end
        PH_PAY: begin
          acc          = 1'b1;
          mem_we       = 1'b1;
          fr_nxt.crc   = crc_feed(fr_r.crc, in_data_byte);
          fr_nxt.count = count_inc;
          if (count_inc >= fr_r.len) begin
            fr_nxt.phase = PH_CRCL;
          end
        end
        PH_CRCL: begin
          acc           = 1'b1;
          fr_nxt.crc_lo = in_data_byte;
          fr_nxt.phase  = PH_CRCH;
        end
        PH_CRCH: begin
          acc = 1'b1;
          if ({in_data_byte, fr_r.crc_lo} == fr_r.crc) begin
            deliver = 1'b1;
            ev      = EV_PKT;
          end else begin
            crc_err_nxt = crc_err_r + 32'd1;
            ev          = EV_CRC_ERR;
          end
          fr_nxt = FRAME_IDLE;
        end
        default: begin
          fr_nxt = FRAME_IDLE;
        end
      endcase
    end
  end

  // Payload memory write port.
  assign mem_addr = fr_r.count[AW-1:0];
  assign mem_data = in_data_byte;

  // Job for the result side; status fields are the values after this word.
  assign q_push           = fire;
  assign q_job.acc        = acc;
  assign q_job.tout       = tout;
  assign q_job.ev         = ev;
  assign q_job.typ        = deliver ? fr_r.typ : 8'h00;
  assign q_job.seq        = deliver ? fr_r.seq : 8'h00;
  assign q_job.len        = deliver ? fr_r.len : '0;
  assign q_job.crc_errors = crc_err_nxt;
  assign q_job.timeouts   = tout_cnt_nxt;
  assign q_job.active     = (fr_nxt.phase != PH_SOF1);

  // A delivered frame blocks input until its last word is shown.
  always_comb begin
    pend_nxt = pend_r;
    if (deliver_done) begin
      pend_nxt = 1'b0;
    end
    if (fire && deliver) begin
      pend_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_r       <= FRAME_IDLE;
      crc_err_r  <= '0;
      tout_cnt_r <= '0;
      pend_r     <= 1'b0;
    end else begin
      fr_r       <= fr_nxt;
      crc_err_r  <= crc_err_nxt;
      tout_cnt_r <= tout_cnt_nxt;
      pend_r     <= pend_nxt;
    end
  end

endmodule

/* rtl/core/frp_queue.sv */
// ----------------------------------------------------------------------------
// Framed packet receiver job queue
// Two-entry FIFO of parser jobs between the front end and the result side.
// ----------------------------------------------------------------------------
module frp_queue
  import frp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head,
  output logic full,
  output logic empty
);

  job_t       slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slot_r[rd_ptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

/* rtl/core/frp_back.sv */
// ----------------------------------------------------------------------------
// Framed packet receiver result side
// Holds the payload memory, turns jobs into result words and walks a
// delivered frame's payload one byte per word into the output register.
// ----------------------------------------------------------------------------
module frp_back
  import frp_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
  parameter int AW          = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  job_t          head,
  input  logic          q_empty,
  output logic          q_pop,
  output logic          deliver_done,
  input  logic          mem_we,
  input  logic [AW-1:0] mem_addr,
  input  logic [7:0]    mem_data,
  output logic          out_valid,
  input  logic          out_stall,
  output res_t          out_res
);

  typedef enum logic [1:0] {
    BK_IDLE = 2'b01,
    BK_RUN  = 2'b10
  } bk_state_t;

  logic [7:0] mem [MAX_PAYLOAD];
  logic [7:0] rd_data_r;

  bk_state_t     state_r, state_nxt;
  job_t          cur_r, cur_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  res_t          out_r, out_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_free;
  logic          run_last;

  // Payload memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_data;
    end
    rd_data_r <= mem[pos_nxt];
  end

  assign out_free = !out_valid_r || !out_stall;
  assign run_last = ((LEN_W'(pos_r) + LEN_W'(1)) == cur_r.len);

  // Result sequencing.
  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    pos_nxt       = pos_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    q_pop         = 1'b0;
    deliver_done  = 1'b0;

    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          if (head.ev == EV_PKT && head.len != '0) begin
            q_pop     = 1'b1;
            cur_nxt   = head;
            pos_nxt   = '0;
            state_nxt = BK_RUN;
          end else if (out_free) begin
            q_pop              = 1'b1;
            out_nxt.acc        = head.acc;
            out_nxt.tout       = head.tout;
            out_nxt.ev         = head.ev;
            out_nxt.typ        = head.typ;
            out_nxt.seq        = head.seq;
            out_nxt.len        = head.len;
            out_nxt.val        = 8'h00;
            out_nxt.pos        = '0;
            out_nxt.last       = 1'b1;
            out_nxt.crc_errors = head.crc_errors;
            out_nxt.timeouts   = head.timeouts;
            out_nxt.active     = head.active;
            out_valid_nxt      = 1'b1;
            deliver_done       = (head.ev == EV_PKT);
          end
        end
      end
      BK_RUN: begin
        if (out_free) begin
          out_nxt.acc        = cur_r.acc;
          out_nxt.tout       = cur_r.tout;
          out_nxt.ev         = cur_r.ev;
          out_nxt.typ        = cur_r.typ;
          out_nxt.seq        = cur_r.seq;
          out_nxt.len        = cur_r.len;
          out_nxt.val        = rd_data_r;
          out_nxt.pos        = POS_W'(pos_r);
          out_nxt.last       = run_last;
          out_nxt.crc_errors = cur_r.crc_errors;
          out_nxt.timeouts   = cur_r.timeouts;
          out_nxt.active     = cur_r.active;
          out_valid_nxt      = 1'b1;
          if (run_last) begin
            state_nxt    = BK_IDLE;
            deliver_done = 1'b1;
          end else begin
            pos_nxt = pos_r + AW'(1);
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule

/* rtl/core/framed_packet_receiver_crc16.sv */
// ----------------------------------------------------------------------------
// Framed packet receiver with CRC-16
// Recognizes start-byte framed packets in a received byte stream, checks
// CRC-16/CCITT-FALSE, and emits good frames as runs of payload words.
// ----------------------------------------------------------------------------
// Each input word (received byte, timeout check, or abort) is taken when
// in_stall is low and yields one result word, except the closing CRC byte
// of a good frame with L > 0 payload bytes, which yields L words. Input is
// held stalled from that byte until its last payload word has entered the
// output register, as the payload is read back one byte per cycle (unless
// the output stalls) from the single read port of the payload memory. A
// two-entry job queue lets the parser take words while the output stalls;
// status fields (error and timeout totals, active) are those after the word.
module framed_packet_receiver_crc16
  import frp_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [7:0]  in_data_byte,
  input  logic [31:0] in_time_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_accepted,
  output logic        out_timed_out,
  output logic [1:0]  out_event_res,
  output logic [7:0]  out_pkt_type,
  output logic [7:0]  out_pkt_sequence,
  output logic [6:0]  out_pkt_length,
  output logic [7:0]  out_payload_value,
  output logic [5:0]  out_payload_position,
  output logic        out_last,
  output logic [31:0] out_crc_errors,
  output logic [31:0] out_timeouts,
  output logic        out_active,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  job_t          push_job, head;
  logic          q_push, q_pop, q_full, q_empty;
  logic          deliver_done;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_data;
  res_t          res;

  frp_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .AW          (AW)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_data_byte (in_data_byte),
    .in_time_ms   (in_time_ms),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_job        (push_job),
    .deliver_done (deliver_done),
    .mem_we       (mem_we),
    .mem_addr     (mem_addr),
    .mem_data     (mem_data)
  );

  frp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  frp_back #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .AW          (AW)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head         (head),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .deliver_done (deliver_done),
    .mem_we       (mem_we),
    .mem_addr     (mem_addr),
    .mem_data     (mem_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_res      (res)
  );

  // Result word fields.
  assign out_accepted         = res.acc;
  assign out_timed_out        = res.tout;
  assign out_event_res        = res.ev;
  assign out_pkt_type         = res.typ;
  assign out_pkt_sequence     = res.seq;
  assign out_pkt_length       = res.len;
  assign out_payload_value    = res.val;
  assign out_payload_position = res.pos;
  assign out_last             = res.last;
  assign out_crc_errors       = res.crc_errors;
  assign out_timeouts         = res.timeouts;
  assign out_active           = res.active;

endmodule
